// File: rtl/g2l_pkg.sv
`timescale 1ns / 1ps

package g2l_pkg;

    localparam int FIRST_YEAR = 1900;
    localparam int YEAR_COUNT = 201;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOK,
        ST_SETUP,
        ST_WALK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic look;
        logic step;
    } cmd_t;

    typedef struct packed {
        logic bad;
        logic walk_done;
    } sts_t;

    function automatic logic [23:0] year_word(input logic [7:0] i);
        logic [23:0] w;
        begin
            unique case (i)
                8'd0: w = 24'h84BEBF;
                8'd1: w = 24'h04AE53; 8'd2: w = 24'h0A5748; 8'd3: w = 24'h5526BD;
                8'd4: w = 24'h0D2650; 8'd5: w = 24'h0D9544; 8'd6: w = 24'h46AAB9;
                8'd7: w = 24'h056A4D; 8'd8: w = 24'h09AD42; 8'd9: w = 24'h24AEB6;
                8'd10: w = 24'h04AE4A; 8'd11: w = 24'h6A4DBE; 8'd12: w = 24'h0A4D52;
                8'd13: w = 24'h0D2546; 8'd14: w = 24'h5D52BA; 8'd15: w = 24'h0B544E;
                8'd16: w = 24'h0D6A43; 8'd17: w = 24'h296D37; 8'd18: w = 24'h095B4B;
                8'd19: w = 24'h749BC1; 8'd20: w = 24'h049754; 8'd21: w = 24'h0A4B48;
                8'd22: w = 24'h5B25BC; 8'd23: w = 24'h06A550; 8'd24: w = 24'h06D445;
                8'd25: w = 24'h4ADAB8; 8'd26: w = 24'h02B64D; 8'd27: w = 24'h095742;
                8'd28: w = 24'h2497B7; 8'd29: w = 24'h04974A; 8'd30: w = 24'h664B3E;
                8'd31: w = 24'h0D4A51; 8'd32: w = 24'h0EA546; 8'd33: w = 24'h56D4BA;
                8'd34: w = 24'h05AD4E; 8'd35: w = 24'h02B644; 8'd36: w = 24'h393738;
                8'd37: w = 24'h092E4B; 8'd38: w = 24'h7C96BF; 8'd39: w = 24'h0C9553;
                8'd40: w = 24'h0D4A48; 8'd41: w = 24'h6DA53B; 8'd42: w = 24'h0B554F;
                8'd43: w = 24'h056A45; 8'd44: w = 24'h4AADB9; 8'd45: w = 24'h025D4D;
                8'd46: w = 24'h092D42; 8'd47: w = 24'h2C95B6; 8'd48: w = 24'h0A954A;
                8'd49: w = 24'h7B4ABD; 8'd50: w = 24'h06CA51; 8'd51: w = 24'h0B5546;
                8'd52: w = 24'h555ABB; 8'd53: w = 24'h04DA4E; 8'd54: w = 24'h0A5B43;
                8'd55: w = 24'h352BB8; 8'd56: w = 24'h052B4C; 8'd57: w = 24'h8A953F;
                8'd58: w = 24'h0E9552; 8'd59: w = 24'h06AA48; 8'd60: w = 24'h6AD53C;
                8'd61: w = 24'h0AB54F; 8'd62: w = 24'h04B645; 8'd63: w = 24'h4A5739;
                8'd64: w = 24'h0A574D; 8'd65: w = 24'h052642; 8'd66: w = 24'h3E9335;
                8'd67: w = 24'h0D9549; 8'd68: w = 24'h75AABE; 8'd69: w = 24'h056A51;
                8'd70: w = 24'h096D46; 8'd71: w = 24'h54AEBB; 8'd72: w = 24'h04AD4F;
                8'd73: w = 24'h0A4D43; 8'd74: w = 24'h4D26B7; 8'd75: w = 24'h0D254B;
                8'd76: w = 24'h8D52BF; 8'd77: w = 24'h0B5452; 8'd78: w = 24'h0B6A47;
                8'd79: w = 24'h696D3C; 8'd80: w = 24'h095B50; 8'd81: w = 24'h049B45;
                8'd82: w = 24'h4A4BB9; 8'd83: w = 24'h0A4B4D; 8'd84: w = 24'hAB25C2;
                8'd85: w = 24'h06A554; 8'd86: w = 24'h06D449; 8'd87: w = 24'h6ADA3D;
                8'd88: w = 24'h0AB651; 8'd89: w = 24'h093746; 8'd90: w = 24'h5497BB;
                8'd91: w = 24'h04974F; 8'd92: w = 24'h064B44; 8'd93: w = 24'h36A537;
                8'd94: w = 24'h0EA54A; 8'd95: w = 24'h86B2BF; 8'd96: w = 24'h05AC53;
                8'd97: w = 24'h0AB647; 8'd98: w = 24'h5936BC; 8'd99: w = 24'h092E50;
                8'd100: w = 24'h0C9645; 8'd101: w = 24'h4D4AB8; 8'd102: w = 24'h0D4A4C;
                8'd103: w = 24'h0DA541; 8'd104: w = 24'h25AAB6; 8'd105: w = 24'h056A49;
                8'd106: w = 24'h7AADBD; 8'd107: w = 24'h025D52; 8'd108: w = 24'h092D47;
                8'd109: w = 24'h5C95BA; 8'd110: w = 24'h0A954E; 8'd111: w = 24'h0B4A43;
                8'd112: w = 24'h4B5537; 8'd113: w = 24'h0AD54A; 8'd114: w = 24'h955ABF;
                8'd115: w = 24'h04BA53; 8'd116: w = 24'h0A5B48; 8'd117: w = 24'h652BBC;
                8'd118: w = 24'h052B50; 8'd119: w = 24'h0A9345; 8'd120: w = 24'h474AB9;
                8'd121: w = 24'h06AA4C; 8'd122: w = 24'h0AD541; 8'd123: w = 24'h24DAB6;
                8'd124: w = 24'h04B64A; 8'd125: w = 24'h69573D; 8'd126: w = 24'h0A4E51;
                8'd127: w = 24'h0D2646; 8'd128: w = 24'h5E933A; 8'd129: w = 24'h0D534D;
                8'd130: w = 24'h05AA43; 8'd131: w = 24'h36B537; 8'd132: w = 24'h096D4B;
                8'd133: w = 24'hB4AEBF; 8'd134: w = 24'h04AD53; 8'd135: w = 24'h0A4D48;
                8'd136: w = 24'h6D25BC; 8'd137: w = 24'h0D254F; 8'd138: w = 24'h0D5244;
                8'd139: w = 24'h5DAA38; 8'd140: w = 24'h0B5A4C; 8'd141: w = 24'h056D41;
                8'd142: w = 24'h24ADB6; 8'd143: w = 24'h049B4A; 8'd144: w = 24'h7A4BBE;
                8'd145: w = 24'h0A4B51; 8'd146: w = 24'h0AA546; 8'd147: w = 24'h5B52BA;
                8'd148: w = 24'h06D24E; 8'd149: w = 24'h0ADA42; 8'd150: w = 24'h355B37;
                8'd151: w = 24'h09374B; 8'd152: w = 24'h8497C1; 8'd153: w = 24'h049753;
                8'd154: w = 24'h064B48; 8'd155: w = 24'h66A53C; 8'd156: w = 24'h0EA54F;
                8'd157: w = 24'h06B244; 8'd158: w = 24'h4AB638; 8'd159: w = 24'h0AAE4C;
                8'd160: w = 24'h092E42; 8'd161: w = 24'h3C9735; 8'd162: w = 24'h0C9649;
                8'd163: w = 24'h7D4ABD; 8'd164: w = 24'h0D4A51; 8'd165: w = 24'h0DA545;
                8'd166: w = 24'h55AABA; 8'd167: w = 24'h056A4E; 8'd168: w = 24'h0A6D43;
                8'd169: w = 24'h452EB7; 8'd170: w = 24'h052D4B; 8'd171: w = 24'h8A95BF;
                8'd172: w = 24'h0A9553; 8'd173: w = 24'h0B4A47; 8'd174: w = 24'h6B553B;
                8'd175: w = 24'h0AD54F; 8'd176: w = 24'h055A45; 8'd177: w = 24'h4A5D38;
                8'd178: w = 24'h0A5B4C; 8'd179: w = 24'h052B42; 8'd180: w = 24'h3A93B6;
                8'd181: w = 24'h069349; 8'd182: w = 24'h7729BD; 8'd183: w = 24'h06AA51;
                8'd184: w = 24'h0AD546; 8'd185: w = 24'h54DABA; 8'd186: w = 24'h04B64E;
                8'd187: w = 24'h0A5743; 8'd188: w = 24'h452738; 8'd189: w = 24'h0D264A;
                8'd190: w = 24'h8E933E; 8'd191: w = 24'h0D5252; 8'd192: w = 24'h0DAA47;
                8'd193: w = 24'h66B53B; 8'd194: w = 24'h056D4F; 8'd195: w = 24'h04AE45;
                8'd196: w = 24'h4A4EB9; 8'd197: w = 24'h0A4D4C; 8'd198: w = 24'h0D1541;
                8'd199: w = 24'h2D92B5; 8'd200: w = 24'h0D5249;
                default: w = 24'h000000;
            endcase
            return w;
        end
    endfunction

    function automatic logic [8:0] days_before(input logic [3:0] m);
        logic [8:0] d;
        begin
            unique case (m)
                4'd1: d = 9'd0;     4'd2: d = 9'd31;    4'd3: d = 9'd59;
                4'd4: d = 9'd90;    4'd5: d = 9'd120;   4'd6: d = 9'd151;
                4'd7: d = 9'd181;   4'd8: d = 9'd212;   4'd9: d = 9'd243;
                4'd10: d = 9'd273;  4'd11: d = 9'd304;  4'd12: d = 9'd334;
                default: d = 9'd0;
            endcase
            return d;
        end
    endfunction

endpackage

// File: rtl/g2l_ctrl.sv
`timescale 1ns / 1ps

module g2l_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              out_stall,
    input  g2l_pkg::sts_t     sts,
    output logic              in_stall,
    output logic              out_valid,
    output g2l_pkg::cmd_t     cmd
);

    g2l_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= g2l_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            g2l_pkg::ST_IDLE:  if (in_valid) state_next = g2l_pkg::ST_LOOK;
            g2l_pkg::ST_LOOK:  state_next = sts.bad ? g2l_pkg::ST_DONE : g2l_pkg::ST_SETUP;
            g2l_pkg::ST_SETUP: state_next = g2l_pkg::ST_WALK;
            g2l_pkg::ST_WALK:  if (sts.walk_done) state_next = g2l_pkg::ST_DONE;
            g2l_pkg::ST_DONE:  if (!out_stall) state_next = g2l_pkg::ST_IDLE;
            default:           state_next = g2l_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall  = (state_reg != g2l_pkg::ST_IDLE);
        out_valid = (state_reg == g2l_pkg::ST_DONE);
        cmd.load  = (state_reg == g2l_pkg::ST_IDLE) && in_valid;
        cmd.look  = (state_reg == g2l_pkg::ST_LOOK);
        cmd.step  = (state_reg == g2l_pkg::ST_WALK) && !sts.walk_done;
    end

    // A result is offered only in the done state, and only one request is in flight.
    assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> in_stall)
        else $error("result offered while accepting");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("stalled result dropped");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == g2l_pkg::ST_LOOK))
        else $error("accepted request not looked up");

endmodule

// File: rtl/g2l_dp.sv
`timescale 1ns / 1ps

module g2l_dp
(
    input  logic              clk,
    input  logic [11:0]       solar_year,
    input  logic [3:0]        solar_month,
    input  logic [4:0]        solar_day,
    input  g2l_pkg::cmd_t     cmd,
    output g2l_pkg::sts_t     sts,
    output logic [11:0]       moon_year,
    output logic [3:0]        moon_month,
    output logic [4:0]        moon_day,
    output logic              intercalary,
    output logic              range_error
);

    logic [11:0] year_reg;
    logic [3:0]  month_reg;
    logic [4:0]  day_reg;
    logic        bad_reg;
    logic        fwd_reg;
    logic [23:0] word_reg;
    logic [8:0]  rem_reg;
    logic [3:0]  idx_reg, lmonth_reg, leap_reg;
    logic        inleap_reg;

    logic [3:0]  month_c;
    logic        is_leap_yr;
    logic [8:0]  sun;
    logic [5:0]  spring;
    logic [7:0]  yoff;
    logic        bad;
    logic [23:0] w_now, w_prev;
    logic [4:0]  len;
    logic [3:0]  leap_p;
    logic [3:0]  idx_n, lm_n;
    logic        il_n;

    assign month_c = (month_reg == 4'd0) ? 4'd1 : ((month_reg > 4'd12) ? 4'd12 : month_reg);
    assign bad = (year_reg < 12'(g2l_pkg::FIRST_YEAR + 1))
              || (year_reg > 12'(g2l_pkg::FIRST_YEAR + g2l_pkg::YEAR_COUNT - 1));
    assign yoff = 8'(year_reg - 12'(g2l_pkg::FIRST_YEAR));
    assign w_now = g2l_pkg::year_word(yoff);
    assign w_prev = g2l_pkg::year_word(yoff - 8'd1);
    // Within the supported years, 2100 is the only century year that is not a leap year.
    assign is_leap_yr = (year_reg[1:0] == 2'b00) && (year_reg != 12'd2100);
    // Both day counts are one above their zero-based values, so day zero of January
    // does not wrap below zero.
    assign spring = 6'({1'b0, w_now[4:0]} + ((w_now[6:5] != 2'd1) ? 6'd31 : 6'd0));
    assign sun = g2l_pkg::days_before(month_c) + 9'(day_reg)
               + ((is_leap_yr && month_c > 4'd2) ? 9'd1 : 9'd0);
    assign leap_p = w_prev[23:20];
    assign len = word_reg[5'd20 - 5'(idx_reg)] ? 5'd30 : 5'd29;

    always_comb
    begin
        idx_n = idx_reg;
        lm_n  = lmonth_reg;
        il_n  = inleap_reg;
        if (fwd_reg)
        begin
            idx_n = idx_reg + 4'd1;
            if (lmonth_reg == leap_reg)
            begin
                il_n = !inleap_reg;
                if (inleap_reg) lm_n = lmonth_reg + 4'd1;
            end
            else
                lm_n = lmonth_reg + 4'd1;
        end
        else
        begin
            idx_n = idx_reg - 4'd1;
            if (!inleap_reg) lm_n = lmonth_reg - 4'd1;
            if (lm_n == leap_reg) il_n = !inleap_reg;
        end
    end

    assign sts.bad = bad;
    assign sts.walk_done = fwd_reg ? (rem_reg < 9'(len) || idx_reg == 4'd13)
                                   : (rem_reg <= 9'(len) || idx_reg == 4'd1);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            year_reg  <= solar_year;
            month_reg <= solar_month;
            day_reg   <= solar_day;
        end
        if (cmd.look)
        begin
            bad_reg <= bad;
            if (sun >= 9'(spring))
            begin
                fwd_reg    <= 1'b1;
                word_reg   <= w_now;
                rem_reg    <= sun - 9'(spring);
                leap_reg   <= w_now[23:20];
                idx_reg    <= 4'd1;
                lmonth_reg <= 4'd1;
                inleap_reg <= 1'b0;
            end
            else
            begin
                fwd_reg    <= 1'b0;
                year_reg   <= year_reg - 12'd1;
                word_reg   <= w_prev;
                rem_reg    <= 9'(spring) - sun;
                leap_reg   <= leap_p;
                idx_reg    <= (leap_p == 4'd0) ? 4'd12 : 4'd13;
                lmonth_reg <= 4'd12;
                inleap_reg <= (leap_p == 4'd12);
            end
        end
        if (cmd.step)
        begin
            rem_reg    <= rem_reg - 9'(len);
            idx_reg    <= idx_n;
            lmonth_reg <= lm_n;
            inleap_reg <= il_n;
        end
    end

    // Output mux reads the final walk registers; they hold until the next request.
    always_comb
    begin
        range_error = bad_reg;
        moon_year   = bad_reg ? 12'd0 : year_reg;
        moon_month  = bad_reg ? 4'd0 : lmonth_reg;
        intercalary = bad_reg ? 1'b0 : inleap_reg;
        if (bad_reg)
            moon_day = 5'd0;
        else if (fwd_reg)
            moon_day = 5'(rem_reg + 9'd1);
        else
            moon_day = 5'(9'(len) - rem_reg + 9'd1);
    end

endmodule

// File: rtl/gregorian_to_lunar_date.sv
`timescale 1ns / 1ps

// Gregorian to Chinese lunar date converter for years 1901 to 2100.
// Input channel: in_valid/in_stall with solar_year, solar_month, solar_day.
// Output channel: out_valid/out_stall with moon_year, moon_month, moon_day,
// intercalary and range_error.
// One request is handled at a time. After acceptance, the controller looks up the
// year table, sets up, then the month walk passes one lunar month slot per cycle
// (up to 12) before the result is offered; the month walk sets the rate.
// A request whose year is out of range skips the setup and the walk and returns
// range_error once the lookup is done.
// in_stall is high from acceptance until the result is taken, and the next
// request can be accepted in the cycle after that.
// While the receiver holds out_stall high the result stays on the ports unchanged.
// Reset returns the controller to idle with no result pending.
module gregorian_to_lunar_date
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [11:0] solar_year,
    input  logic [3:0]  solar_month,
    input  logic [4:0]  solar_day,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [11:0] moon_year,
    output logic [3:0]  moon_month,
    output logic [4:0]  moon_day,
    output logic        intercalary,
    output logic        range_error
);

    g2l_pkg::cmd_t cmd;
    g2l_pkg::sts_t sts;

    g2l_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    g2l_dp u_dp
    (
        .clk         (clk),
        .solar_year  (solar_year),
        .solar_month (solar_month),
        .solar_day   (solar_day),
        .cmd         (cmd),
        .sts         (sts),
        .moon_year   (moon_year),
        .moon_month  (moon_month),
        .moon_day    (moon_day),
        .intercalary (intercalary),
        .range_error (range_error)
    );

endmodule
